// File: rtl/hash_probe_table_lookup_top_assert.svh
// Assertion macros for the hash probe table lookup block.
`ifndef HASH_PROBE_TABLE_LOOKUP_TOP_ASSERT_SVH
`define HASH_PROBE_TABLE_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HPT_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hpt_pkg.sv
// Shared types and constants of the hash probe table lookup block.
package hpt_pkg;

  localparam int unsigned CfgW    = 11;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 64;
  localparam int unsigned StatusW = 3;

  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_LOOKUP  = 2'd1,
    FUNC_SWAP    = 2'd2,
    FUNC_RESTORE = 2'd3
  } hpt_func_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 3'd0,
    STS_EMPTY_HIT = 3'd1,
    STS_EXHAUSTED = 3'd2,
    STS_CUR_NULL  = 3'd3,
    STS_MISMATCH  = 3'd4,
    STS_NULL_OP   = 3'd5
  } hpt_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } hpt_state_e;

  // Request to and response from the serial remainder unit.
  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] dividend;
    logic [CfgW-1:0] divisor;
  } hpt_div_req_t;

  typedef struct packed {
    logic            done;
    logic [CfgW-1:0] rem;
  } hpt_div_rsp_t;

endpackage

// File: rtl/hash_probe_table_lookup_top.sv
// Top level of the open-addressing hash table lookup block.
// Flow: a load or a rejected operand goes from acceptance straight to the finish state; a search
//   runs each probe through the 32-step serial remainder, the read and the check, then finishes.
// Throughput: one transaction at a time; the serial remainder unit sets the probe cost.
// Reset: control clears at once, then a clearing pass writes all TABLE_SLOTS entries to zero,
//   one per cycle; no input transaction is taken until it ends (configuration writes are).
`include "hash_probe_table_lookup_top_assert.svh"

module hash_probe_table_lookup_top
  import hpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: modulus (slots taking part in probing)
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // input transaction
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [SlotW-1:0]   slot_index_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [ValW-1:0]    new_value_i,
  input  logic [ValW-1:0]    expected_value_i,
  // result transaction
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   entry_slot_o,
  output logic [ValW-1:0]    value_o
);

  localparam int unsigned IdxW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned WordW = KeyW + ValW;

  // Slot memory: key in the upper bits, value in the lower bits.
  logic [WordW-1:0] slot_mem [TABLE_SLOTS];
  logic [WordW-1:0] mem_rdata_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [KeyW-1:0]  rd_key;
  logic [ValW-1:0]  rd_val;

  hpt_state_e       state_q, state_d;
  logic [CfgW-1:0]  slots_cfg_q;
  logic [CfgW-1:0]  eff_m;
  logic [IdxW-1:0]  clr_idx_q, clr_idx_d;

  // Transaction held while it is worked on
  hpt_func_e        func_q, func_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [ValW-1:0]  new_val_q, new_val_d;
  logic [ValW-1:0]  exp_val_q, exp_val_d;
  logic [CfgW-1:0]  m_q, m_d;
  logic [KeyW-1:0]  step_q, step_d, step_nxt;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CfgW-1:0]  probe_cnt_q, probe_cnt_d;

  // Finished result waiting for the output register
  hpt_status_e      res_status_q, res_status_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic [ValW-1:0]  res_value_q, res_value_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  hpt_status_e      out_status_q;
  logic [SlotW-1:0] out_slot_q;
  logic [ValW-1:0]  out_value_q;

  hpt_div_req_t     div_req;
  hpt_div_rsp_t     div_rsp;

  hpt_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A modulus above the table size acts as the table size.
  always_comb begin
    if (32'(slots_cfg_q) > 32'(TABLE_SLOTS)) begin
      eff_m = CfgW'(TABLE_SLOTS);
    end else begin
      eff_m = slots_cfg_q;
    end
  end

  assign rd_key   = mem_rdata_q[WordW-1:ValW];
  assign rd_val   = mem_rdata_q[ValW-1:0];
  assign step_nxt = (step_q >> 1) + 32'd1;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    func_d       = func_q;
    key_d        = key_q;
    new_val_d    = new_val_q;
    exp_val_d    = exp_val_q;
    m_d          = m_q;
    step_d       = step_q;
    idx_d        = idx_q;
    probe_cnt_d  = probe_cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_value_d  = res_value_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = {key_q, new_val_q};
    div_req      = '{start: 1'b0, dividend: key_q, divisor: m_q};
    out_load     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // zero one entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = IdxW'(clr_idx_q + 1'b1);
        if (32'(clr_idx_q) == TABLE_SLOTS - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          func_d       = hpt_func_e'(func_i);
          key_d        = key_i;
          new_val_d    = new_value_i;
          exp_val_d    = expected_value_i;
          m_d          = eff_m;
          step_d       = key_i;
          probe_cnt_d  = '0;
          res_status_d = STS_OK;
          res_slot_d   = '0;
          res_value_d  = '0;
          if (hpt_func_e'(func_i) == FUNC_LOAD) begin
            // raw write; an index beyond the table writes nothing
            mem_we      = (32'(slot_index_i) < TABLE_SLOTS);
            mem_waddr   = IdxW'(slot_index_i);
            mem_wdata   = {key_i, new_value_i};
            res_slot_d  = slot_index_i;
            res_value_d = new_value_i;
            state_d     = ST_FINISH;
          end else if ((hpt_func_e'(func_i) == FUNC_SWAP && new_value_i == '0) ||
                       (hpt_func_e'(func_i) == FUNC_RESTORE &&
                        (new_value_i == '0 || expected_value_i == '0))) begin
            res_status_d = STS_NULL_OP;
            state_d      = ST_FINISH;
          end else if (eff_m == '0) begin
            res_status_d = STS_EXHAUSTED;
            state_d      = ST_FINISH;
          end else begin
            // first probe index: key mod M
            div_req = '{start: 1'b1, dividend: key_i, divisor: eff_m};
            state_d = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          idx_d   = IdxW'(div_rsp.rem);
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        if (rd_key == key_q) begin
          res_slot_d = SlotW'(idx_q);
          unique case (func_q)
            FUNC_LOOKUP, FUNC_LOAD: begin
              res_value_d = rd_val;
            end
            FUNC_SWAP: begin
              if (rd_val == '0) begin
                res_status_d = STS_CUR_NULL;
              end else begin
                mem_we      = 1'b1;
                res_value_d = rd_val;
              end
            end
            FUNC_RESTORE: begin
              res_value_d = rd_val;
              if (rd_val != exp_val_q) begin
                res_status_d = STS_MISMATCH;
              end else begin
                mem_we = 1'b1;
              end
            end
            default: begin
              res_value_d = rd_val;
            end
          endcase
          state_d = ST_FINISH;
        end else if (rd_key == '0) begin
          res_status_d = STS_EMPTY_HIT;
          state_d      = ST_FINISH;
        end else if (CfgW'(probe_cnt_q + 1'b1) == m_q) begin
          res_status_d = STS_EXHAUSTED;
          state_d      = ST_FINISH;
        end else begin
          // advance: halve step plus one, next index (index + step) mod M
          probe_cnt_d = CfgW'(probe_cnt_q + 1'b1);
          step_d      = step_nxt;
          div_req     = '{start: 1'b1, dividend: step_nxt + 32'(idx_q), divisor: m_q};
          state_d     = ST_DIV;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      slots_cfg_q <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slots_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    new_val_q    <= new_val_d;
    exp_val_q    <= exp_val_d;
    m_q          <= m_d;
    step_q       <= step_d;
    idx_q        <= idx_d;
    probe_cnt_q  <= probe_cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_value_q  <= res_value_q;
    end
  end

  // Slot memory: one write and one registered read per cycle. Accesses never
  // overlap: the read is issued only in its own state and the write never in that state.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= slot_mem[idx_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign entry_slot_o = out_slot_q;
  assign value_o      = out_value_q;

  `HPT_ASSERT_IMM(a_div_done_in_div, div_rsp.done, state_q == ST_DIV, "remainder done outside divide state")
  `HPT_ASSERT_IMM(a_no_rw_overlap, mem_we, !mem_re, "slot memory read and write in one cycle")
  `HPT_ASSERT_IMM(a_probe_bound, state_q == ST_CHECK, probe_cnt_q < m_q, "probe count reached modulus")
  `HPT_ASSERT_IMM(a_clear_quiet, state_q == ST_CLEAR, !out_valid_q, "result present during clearing pass")
  `HPT_ASSERT_NXT(a_finish_emits, out_load, out_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule

// File: rtl/hpt_mod_unit.sv
// Serial remainder unit: one dividend bit per cycle, restoring scheme.
module hpt_mod_unit
  import hpt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hpt_div_req_t req_i,
  output hpt_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(KeyW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [KeyW-1:0] dvd_q, dvd_d;
  logic [CfgW-1:0] dvs_q, dvs_d;
  logic [CfgW-1:0] rem_q, rem_d;
  logic [CfgW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[KeyW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CfgW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = CfgW'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(KeyW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: tb/hpt_lookup_checker.sv
// Result checker for the hash probe table lookup block: shadow table, prediction, comparison.
`timescale 1ns / 100ps

module hpt_lookup_checker
  import hpt_pkg::*;
#(
  parameter int unsigned TableSlots = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [SlotW-1:0]   slot_index_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [ValW-1:0]    new_value_i,
  input  logic [ValW-1:0]    expected_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [SlotW-1:0]   entry_slot_i,
  input  logic [ValW-1:0]    value_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    hpt_status_e      status;
    logic [SlotW-1:0] entry_slot;
    logic [ValW-1:0]  value;
  } lookup_result_t;

  logic [KeyW-1:0] slot_keys   [TableSlots];
  logic [ValW-1:0] slot_values [TableSlots];
  logic [CfgW-1:0] modulus;
  lookup_result_t  awaited_results [$];

  // Walk the probe sequence of a key over the shadow table.
  function automatic hpt_status_e walk_probe(input logic [KeyW-1:0] key,
                                             output logic [SlotW-1:0] hit_slot);
    int unsigned     m;
    int unsigned     idx;
    int unsigned     n;
    logic [KeyW-1:0] step;
    hit_slot = '0;
    m = (modulus > TableSlots) ? TableSlots : modulus;
    if (m == 0) return STS_EXHAUSTED;
    idx  = key % m;
    step = key;
    for (n = 0; n < m; n++) begin
      if (slot_keys[idx] == key) begin
        hit_slot = idx[SlotW-1:0];
        return STS_OK;
      end
      if (slot_keys[idx] == '0) return STS_EMPTY_HIT;
      step = (step >> 1) + 1'b1;
      idx  = 32'((64'(step) + 64'(idx)) % m);
    end
    return STS_EXHAUSTED;
  endfunction

  // Apply one transaction to the shadow table and return what the block must answer.
  function automatic lookup_result_t predict_result(input hpt_func_e        func,
                                                    input logic [SlotW-1:0] sidx,
                                                    input logic [KeyW-1:0]  key,
                                                    input logic [ValW-1:0]  nv,
                                                    input logic [ValW-1:0]  ev);
    lookup_result_t   res;
    logic [SlotW-1:0] hit_slot;
    logic [ValW-1:0]  cur;
    res.status     = STS_OK;
    res.entry_slot = '0;
    res.value      = '0;
    if (func == FUNC_LOAD) begin
      if (sidx < TableSlots) begin
        slot_keys[sidx]   = key;
        slot_values[sidx] = nv;
      end
      res.entry_slot = sidx;
      res.value      = nv;
    end else if ((func == FUNC_SWAP && nv == '0) ||
                 (func == FUNC_RESTORE && (nv == '0 || ev == '0))) begin
      res.status = STS_NULL_OP;
    end else begin
      res.status = walk_probe(key, hit_slot);
      if (res.status == STS_OK) begin
        cur            = slot_values[hit_slot];
        res.entry_slot = hit_slot;
        res.value      = cur;
        case (func)
          FUNC_SWAP: begin
            if (cur == '0) res.status = STS_CUR_NULL;
            else slot_values[hit_slot] = nv;
          end
          FUNC_RESTORE: begin
            if (cur != ev) res.status = STS_MISMATCH;
            else slot_values[hit_slot] = nv;
          end
          default: ;
        endcase
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    lookup_result_t want;
    int unsigned    s;
    if (!rst_ni) begin
      for (s = 0; s < TableSlots; s++) begin
        slot_keys[s]   = '0;
        slot_values[s] = '0;
      end
      modulus = CfgReset;
      awaited_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) modulus = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(predict_result(hpt_func_e'(func_i), slot_index_i, key_i,
                                                 new_value_i, expected_value_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected result: status %0d slot %0d value %h",
                     $time, status_i, entry_slot_i, value_i);
        end else begin
          want = awaited_results.pop_front();
          if (status_i !== want.status || entry_slot_i !== want.entry_slot ||
              value_i !== want.value) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("[%0t] mismatch: want status %0d slot %0d value %h, got %0d %0d %h",
                       $time, want.status, want.entry_slot, want.value,
                       status_i, entry_slot_i, value_i);
          end
        end
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

// File: tb/hash_probe_table_lookup_top_test.sv
// Stimulus and verdict for the hash probe table lookup block, with its checker alongside.
`timescale 1ns / 100ps

module hash_probe_table_lookup_top_test;
  import hpt_pkg::*;

  localparam int unsigned TableSlots = 1024;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [FuncW-1:0]   func      = '0;
  logic [SlotW-1:0]   slot_index = '0;
  logic [KeyW-1:0]    key       = '0;
  logic [ValW-1:0]    new_value = '0;
  logic [ValW-1:0]    expected_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   entry_slot;
  logic [ValW-1:0]    value;
  int unsigned        fail_count;
  int unsigned        pending;

  // Per-phase pools: keys and values are reused so that searches hit and restores match.
  logic [KeyW-1:0]    key_pool   [8];
  logic [ValW-1:0]    value_pool [4];
  int unsigned        send_calm = 0;
  int unsigned        sink_calm = 0;

  hash_probe_table_lookup_top #(
    .TABLE_SLOTS(TableSlots)
  ) uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .slot_index_i     (slot_index),
    .key_i            (key),
    .new_value_i      (new_value),
    .expected_value_i (expected_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .entry_slot_o     (entry_slot),
    .value_o          (value)
  );

  hpt_lookup_checker #(
    .TableSlots(TableSlots)
  ) results_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (func),
    .slot_index_i     (slot_index),
    .key_i            (key),
    .new_value_i      (new_value),
    .expected_value_i (expected_value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .entry_slot_i     (entry_slot),
    .value_i          (value),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run, including the clearing pass after reset.
  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long, with calm stretches of no idling.
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(19) == 0) begin
      calm = $urandom_range(60, 15);
      return 0;
    end
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  // Pick a key: mostly from the pool, sometimes zero (the empty marker), sometimes anything.
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return key_pool[$urandom_range(7)];
    if (r < 90) return '0;
    return $urandom();
  endfunction

  // Pick a value: mostly from the pool, sometimes zero (null), sometimes anything.
  function automatic logic [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return value_pool[$urandom_range(3)];
    if (r < 88) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // Offer one transaction; return once it has been taken. Valid is held across back-to-back
  // transactions and dropped only when an idle gap comes first.
  task automatic send_item(input hpt_func_e        f,
                           input logic [SlotW-1:0] sidx,
                           input logic [KeyW-1:0]  k,
                           input logic [ValW-1:0]  nv,
                           input logic [ValW-1:0]  ev);
    int unsigned gap;
    gap = next_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func           <= f;
    slot_index     <= sidx;
    key            <= k;
    new_value      <= nv;
    expected_value <= ev;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write the modulus only once every outstanding result has come back: each transaction
  // gives exactly one result, so an empty expectation list means the block is idle.
  task automatic write_modulus(input logic [CfgW-1:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase at a given modulus. Keep the pools small so that loads land on the
  // probe paths of later searches, and mix in stray keys, slots and values as noise.
  task automatic run_phase(input logic [CfgW-1:0] m, input int unsigned count);
    int unsigned      eff;
    int unsigned      r;
    int unsigned      n;
    int unsigned      k;
    hpt_func_e        f;
    logic [SlotW-1:0] sidx;
    eff = (m > TableSlots) ? TableSlots : m;
    write_modulus(m);
    for (k = 0; k < 8; k++)
      key_pool[k] = (k < 4) ? KeyW'($urandom_range(2 * eff + 3, 1)) : KeyW'($urandom());
    for (k = 0; k < 4; k++) begin
      value_pool[k] = {$urandom(), $urandom()};
      if (value_pool[k] == '0) value_pool[k] = 64'd1;
    end
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 30)      f = FUNC_LOAD;
      else if (r < 60) f = FUNC_LOOKUP;
      else if (r < 80) f = FUNC_SWAP;
      else             f = FUNC_RESTORE;
      if (eff == 0 || $urandom_range(9) == 0) sidx = SlotW'($urandom_range(TableSlots - 1));
      else sidx = SlotW'($urandom_range(eff - 1));
      send_item(f, sidx, pick_key(), pick_value(), pick_value());
    end
  endtask

  // Result side: stall at random, in step with the clock's falling edge.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = next_gap(sink_calm);
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on a table of eight slots.
    write_modulus(11'd8);
    // empty table: the first probe hits an empty slot
    send_item(FUNC_LOOKUP, '0, 32'd5, '0, '0);
    // key zero matches the first empty slot it reaches
    send_item(FUNC_LOOKUP, '0, '0, '0, '0);
    send_item(FUNC_LOAD, 10'd5, 32'd5, 64'h0123_4567_89AB_CDEF, '0);
    send_item(FUNC_LOOKUP, '0, 32'd5, '0, '0);
    // key 13 starts on slot 5 (taken) and moves on to slot 4
    send_item(FUNC_LOAD, 10'd4, 32'd13, 64'hFEDC_BA98_7654_3210, '0);
    send_item(FUNC_LOOKUP, '0, 32'd13, '0, '0);
    // swap with a null operand, then a real swap
    send_item(FUNC_SWAP, '0, 32'd5, '0, '0);
    send_item(FUNC_SWAP, '0, 32'd5, 64'hA5A5_5A5A_0F0F_F0F0, '0);
    // swap on a slot whose current value is null
    send_item(FUNC_LOAD, 10'd2, 32'd2, '0, '0);
    send_item(FUNC_SWAP, '0, 32'd2, 64'h1111_2222_3333_4444, '0);
    // restore: mismatch, then a match
    send_item(FUNC_RESTORE, '0, 32'd5, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_item(FUNC_RESTORE, '0, 32'd5, 64'h0123_4567_89AB_CDEF, 64'hA5A5_5A5A_0F0F_F0F0);
    // restore with either operand null
    send_item(FUNC_RESTORE, '0, 32'd5, '0, 64'h0123_4567_89AB_CDEF);
    send_item(FUNC_RESTORE, '0, 32'd5, 64'h0123_4567_89AB_CDEF, '0);
    // field extremes; the top slot sits outside the current modulus
    send_item(FUNC_LOAD, '1, '1, '1, '0);
    send_item(FUNC_LOOKUP, '0, '1, '0, '1);
    send_item(FUNC_LOAD, '0, '0, '0, '0);
    // two full slots and a missing key: every probe is used up
    write_modulus(11'd2);
    send_item(FUNC_LOAD, 10'd0, 32'd7, 64'h0123_4567_89AB_CDEF, '0);
    send_item(FUNC_LOAD, 10'd1, 32'd9, 64'hFEDC_BA98_7654_3210, '0);
    send_item(FUNC_LOOKUP, '0, 32'd4, '0, '0);
    // modulus zero: no probes at all
    write_modulus(11'd0);
    send_item(FUNC_LOOKUP, '0, 32'd7, '0, '0);
    send_item(FUNC_SWAP, '0, 32'd9, 64'h5555_AAAA_5555_AAAA, '0);
    // modulus above the table size acts as the full table; the top slot is reachable
    write_modulus(11'd2047);
    send_item(FUNC_LOOKUP, '0, '1, '0, '0);

    // Random phases: small moduli keep probe walks short, a few visit the extremes.
    run_phase(11'd8, 150);
    run_phase(11'd1, 80);
    run_phase(11'd2, 100);
    run_phase(11'd3, 120);
    run_phase(11'd16, 200);
    run_phase(11'd5, 150);
    run_phase(11'd31, 200);
    run_phase(11'd0, 60);
    run_phase(11'd1024, 80);
    run_phase(11'd2047, 60);
    run_phase(11'd4, 150);
    run_phase(11'd12, 200);
    run_phase(11'd7, 200);

    // Drain: drop valid, wait for every result, then let the clock run on before the verdict.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
